/* design/lialu_pkg.sv */
`timescale 1ns / 1ps

package lialu_pkg;

  localparam int REG_COUNT_DEF = 64;

  localparam int DATA_W  = 16;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 4;
  localparam int FLAGS_W = 16;

  // Opcodes. Codes above OP_SIMM are treated as no-ops.
  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_AND  = 4'd2;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd3;
  localparam logic [OP_W-1:0] OP_ADDI = 4'd4;
  localparam logic [OP_W-1:0] OP_SUBI = 4'd5;
  localparam logic [OP_W-1:0] OP_SHL  = 4'd6;
  localparam logic [OP_W-1:0] OP_SHR  = 4'd7;
  localparam logic [OP_W-1:0] OP_IMM  = 4'd8;
  localparam logic [OP_W-1:0] OP_SIMM = 4'd9;

  localparam logic [DATA_W-1:0] SIGN_MASK    = 16'h8000;
  localparam logic [IDX_W-1:0]  SHR_ARITH    = 6'o40;
  localparam logic [IDX_W-1:0]  SHR_AMT_MASK = 6'o37;
  localparam logic [DATA_W-1:0] SIMM_EXT     = 16'hF000;

  // Flag pair positions: bit pos holds the condition, bit pos+1 its complement.
  localparam int FB_Z  = 0;
  localparam int FB_C  = 2;
  localparam int FB_N  = 4;
  localparam int FB_P  = 6;
  localparam int FB_V  = 8;
  localparam int FB_O  = 10;
  localparam int FB_LT = 12;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] dest_reg;
    logic [IDX_W-1:0] src_a;
    logic [IDX_W-1:0] src_b;
  } in_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [DATA_W-1:0]  write_value;
    logic [FLAGS_W-1:0] flag_vector;
  } out_item_t;

  function automatic logic [FLAGS_W-1:0] make_flags(input logic [DATA_W-1:0] r,
                                                    input logic carry,
                                                    input logic ovf);
    logic [FLAGS_W-1:0] f;
    logic neg;
    logic zero;
    neg  = |(r & SIGN_MASK);
    zero = (r == '0);
    f = '0;
    f[FB_Z]    = zero;
    f[FB_Z+1]  = !zero;
    f[FB_C]    = carry;
    f[FB_C+1]  = !carry;
    f[FB_N]    = neg;
    f[FB_N+1]  = !neg;
    f[FB_P]    = !zero && !neg;
    f[FB_P+1]  = zero || neg;
    f[FB_V]    = ovf;
    f[FB_V+1]  = !ovf;
    f[FB_O]    = r[0];
    f[FB_O+1]  = !r[0];
    f[FB_LT]   = neg ^ ovf;
    f[FB_LT+1] = !(neg ^ ovf);
    return f;
  endfunction

endpackage

/* design/lane_integer_alu_with_flags_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                              Direction
// input     in_valid, in_ready, in_data        instruction transfer into the lane
// result    out_valid, out_ready, out_data     write report and flags out of the lane
//
// One instruction per cycle sustained while the result channel is not stalled. A result
// passes through the execute-stage register and the result register before it is
// offered. The register file is a two-read-port synchronous memory, so operands arrive
// in the cycle after acceptance; the execute stage forwards the most recent write. Reset
// clears the flags and the per-register valid bits at once, so no sweep is needed. A
// stalled result register holds the execute stage, which in turn holds input.

module lane_integer_alu_with_flags_top #(
  parameter int REG_COUNT = lialu_pkg::REG_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lialu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lialu_pkg::out_item_t out_data
);

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [lialu_pkg::IDX_W:0] REG_LIM = (lialu_pkg::IDX_W + 1)'(REG_COUNT);

  logic [lialu_pkg::DATA_W-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  logic in_fire;
  logic s1_adv;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic ra_ok;
  logic rb_ok;

  logic s1_v_r;
  lialu_pkg::in_item_t s1_r;
  logic [lialu_pkg::DATA_W-1:0] rd_a_r;
  logic [lialu_pkg::DATA_W-1:0] rd_b_r;
  logic rd_vld_a_r;
  logic rd_vld_b_r;

  logic wb_en_r;
  logic [lialu_pkg::IDX_W-1:0] wb_addr_r;
  logic [lialu_pkg::DATA_W-1:0] wb_data_r;

  logic [lialu_pkg::FLAGS_W-1:0] flag_r;
  logic [lialu_pkg::FLAGS_W-1:0] flag_nxt;

  logic out_valid_r;
  lialu_pkg::out_item_t out_data_r;

  logic [lialu_pkg::DATA_W-1:0] opa;
  logic [lialu_pkg::DATA_W-1:0] opb;
  logic [lialu_pkg::DATA_W-1:0] addb;
  logic [lialu_pkg::DATA_W-1:0] res;
  logic [lialu_pkg::DATA_W-1:0] sum;
  logic [lialu_pkg::DATA_W-1:0] diff;
  logic [3:0] sra_amt;
  logic carry;
  logic ovf;
  logic is_alu;
  logic writes;
  logic dst_ok;
  logic mem_we;

  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);

  assign ra_ok = ({1'b0, in_data.src_a} < REG_LIM);
  assign rb_ok = ({1'b0, in_data.src_b} < REG_LIM);
  assign ra    = ra_ok ? in_data.src_a[AW-1:0] : '0;
  assign rb    = rb_ok ? in_data.src_b[AW-1:0] : '0;

  // Register file read: data is registered and held while the execute stage stalls.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a_r     <= mem[ra];
      rd_b_r     <= mem[rb];
      rd_vld_a_r <= vld_r[ra];
      rd_vld_b_r <= vld_r[rb];
      s1_r       <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_r.dest_reg[AW-1:0]] <= res;
    end
  end

  // Operand selection: register zero and out-of-range indexes read zero; the last
  // write may have landed at the same edge as the read, so it is forwarded.
  always_comb begin
    opa = '0;
    if (s1_r.src_a != '0 && ({1'b0, s1_r.src_a} < REG_LIM)) begin
      if (wb_en_r && wb_addr_r == s1_r.src_a) begin
        opa = wb_data_r;
      end else if (rd_vld_a_r) begin
        opa = rd_a_r;
      end
    end
    opb = '0;
    if (s1_r.src_b != '0 && ({1'b0, s1_r.src_b} < REG_LIM)) begin
      if (wb_en_r && wb_addr_r == s1_r.src_b) begin
        opb = wb_data_r;
      end else if (rd_vld_b_r) begin
        opb = rd_b_r;
      end
    end
  end

  always_comb begin
    addb = (s1_r.op == lialu_pkg::OP_ADDI || s1_r.op == lialu_pkg::OP_SUBI) ?
           {{(lialu_pkg::DATA_W - lialu_pkg::IDX_W){1'b0}}, s1_r.src_b} : opb;
    sum  = opa + addb;
    diff = opa - addb;
    sra_amt = s1_r.src_b[4] ? 4'd15 : s1_r.src_b[3:0];
    res    = '0;
    carry  = 1'b0;
    ovf    = 1'b0;
    is_alu = 1'b1;
    writes = 1'b1;
    unique case (s1_r.op)
      lialu_pkg::OP_ADD, lialu_pkg::OP_ADDI: begin
        res   = sum;
        carry = (sum < opa);
        ovf   = !((opa[15] ^ addb[15])) && (sum[15] ^ opa[15]);
      end
      lialu_pkg::OP_SUB, lialu_pkg::OP_SUBI: begin
        res   = diff;
        carry = (diff < opa);
        ovf   = (opa[15] ^ addb[15]) && (diff[15] ^ opa[15]);
      end
      lialu_pkg::OP_AND: res = opa & opb;
      lialu_pkg::OP_XOR: res = opa ^ opb;
      lialu_pkg::OP_SHL: begin
        res = (s1_r.src_b[5] || s1_r.src_b[4]) ? '0 : (opa << s1_r.src_b[3:0]);
      end
      lialu_pkg::OP_SHR: begin
        if ((s1_r.src_b & lialu_pkg::SHR_ARITH) != '0) begin
          res = $unsigned($signed(opa) >>> sra_amt);
        end else begin
          res = s1_r.src_b[4] ? '0 : (opa >> s1_r.src_b[3:0]);
        end
      end
      lialu_pkg::OP_IMM, lialu_pkg::OP_SIMM: begin
        is_alu = 1'b0;
        res = {{(lialu_pkg::DATA_W - 2 * lialu_pkg::IDX_W){1'b0}}, s1_r.src_a, s1_r.src_b};
        if (s1_r.op == lialu_pkg::OP_SIMM && s1_r.src_a[5]) begin
          res = res | lialu_pkg::SIMM_EXT;
        end
      end
      default: begin
        is_alu = 1'b0;
        writes = 1'b0;
      end
    endcase
    flag_nxt = is_alu ? lialu_pkg::make_flags(res, carry, ovf) : flag_r;
  end

  assign dst_ok = ({1'b0, s1_r.dest_reg} < REG_LIM);
  assign mem_we = s1_adv && writes && dst_ok && (s1_r.dest_reg != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      wb_en_r     <= 1'b0;
      flag_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        flag_r      <= flag_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[s1_r.dest_reg[AW-1:0]] <= 1'b1;
        wb_en_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wb_addr_r <= s1_r.dest_reg;
      wb_data_r <= res;
    end
    if (s1_adv) begin
      out_data_r.write_enable <= writes && dst_ok;
      out_data_r.write_value  <= (writes && dst_ok) ? res : '0;
      out_data_r.flag_vector  <= flag_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/tb_lane_integer_alu_with_flags_top.sv */
`timescale 1ns / 1ps

module tb_lane_integer_alu_with_flags_top;
  import lialu_pkg::*;

  // Opcodes past OP_SIMM do nothing; these mark the two ends of that range.
  localparam logic [OP_W-1:0] OP_IDLE_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_IDLE_LAST  = 4'd15;

  // Flags left by any ALU result of zero with no carry and no overflow.
  localparam logic [FLAGS_W-1:0] FLAGS_ZERO_RESULT = 16'h2AA9;

  localparam int RANDOM_INSTRS = 1550;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    in_item_t  instr;
    logic      known;
    out_item_t result;
  } lane_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Shadow copy of the lane state, updated once per accepted instruction.
  logic [DATA_W-1:0]  shadow_regs [REG_COUNT_DEF];
  logic [FLAGS_W-1:0] shadow_flags;
  out_item_t          pending_results [$];

  int unsigned errors = 0;
  int unsigned issued = 0;
  int unsigned checked = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_ops = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned out_stall_left = 0;

  lane_integer_alu_with_flags_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [DATA_W-1:0] shadow_read(input logic [IDX_W-1:0] idx);
    if (idx == '0 || idx >= REG_COUNT_DEF) begin
      return '0;
    end
    return shadow_regs[idx];
  endfunction

  function automatic logic [1:0] cond_pair(input logic c);
    return c ? 2'b01 : 2'b10;
  endfunction

  function automatic logic [FLAGS_W-1:0] flag_word(input logic [DATA_W-1:0] r,
                                                   input logic carry,
                                                   input logic ovf);
    logic [FLAGS_W-1:0] w;
    logic               neg;
    neg = r[DATA_W-1];
    w = '0;
    w[FB_Z +: 2]  = cond_pair(r == '0);
    w[FB_C +: 2]  = cond_pair(carry);
    w[FB_N +: 2]  = cond_pair(neg);
    w[FB_P +: 2]  = cond_pair(r != '0 && !neg);
    w[FB_V +: 2]  = cond_pair(ovf);
    w[FB_O +: 2]  = cond_pair(r[0]);
    w[FB_LT +: 2] = cond_pair(neg ^ ovf);
    return w;
  endfunction

  // Executes one instruction on the shadow state and returns the report it causes.
  function automatic out_item_t lane_execute(input in_item_t instr);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic              carry;
    logic              ovf;
    logic              alu;
    logic              wr;
    int unsigned       n;
    out_item_t         rep;
    a = shadow_read(instr.src_a);
    b = shadow_read(instr.src_b);
    r = '0;
    carry = 1'b0;
    ovf = 1'b0;
    alu = 1'b1;
    wr = 1'b1;
    case (instr.op)
      OP_ADD, OP_ADDI: begin
        if (instr.op == OP_ADDI) b = DATA_W'(instr.src_b);
        r = a + b;
        carry = r < a;
        ovf = (a[DATA_W-1] == b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
      end
      OP_SUB, OP_SUBI: begin
        if (instr.op == OP_SUBI) b = DATA_W'(instr.src_b);
        r = a - b;
        carry = r < a;
        ovf = (a[DATA_W-1] != b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
      end
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_SHL: r = (instr.src_b >= 16) ? '0 : a << instr.src_b;
      OP_SHR: begin
        if ((instr.src_b & SHR_ARITH) != '0) begin
          n = 32'(instr.src_b & SHR_AMT_MASK);
          if (n > 15) n = 15;
          r = $signed(a) >>> n;
        end else begin
          r = (instr.src_b >= 16) ? '0 : a >> instr.src_b;
        end
      end
      OP_IMM, OP_SIMM: begin
        alu = 1'b0;
        r = {4'b0, instr.src_a, instr.src_b};
        if (instr.op == OP_SIMM && instr.src_a[IDX_W-1]) r = r + SIMM_EXT;
      end
      default: begin
        alu = 1'b0;
        wr = 1'b0;
      end
    endcase
    if (alu) shadow_flags = flag_word(r, carry, ovf);
    if (wr && instr.dest_reg >= REG_COUNT_DEF) wr = 1'b0;
    if (wr && instr.dest_reg != '0) shadow_regs[instr.dest_reg] = r;
    rep.write_enable = wr;
    rep.write_value  = wr ? r : '0;
    rep.flag_vector  = shadow_flags;
    return rep;
  endfunction

  function automatic lane_row_t row(input logic [OP_W-1:0] op, input int d, input int a,
                                    input int b, input bit known = 1'b0,
                                    input bit we = 1'b0,
                                    input logic [DATA_W-1:0] val = '0,
                                    input logic [FLAGS_W-1:0] flags = '0);
    lane_row_t t;
    t.instr = '{op: op, dest_reg: IDX_W'(d), src_a: IDX_W'(a), src_b: IDX_W'(b)};
    t.known = known;
    t.result = '{write_enable: we, write_value: val, flag_vector: flags};
    return t;
  endfunction

  // Registers are drawn mostly from a small window so that dependent
  // instructions often follow each other closely.
  function automatic logic [IDX_W-1:0] pick_reg();
    return ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7))
                                       : IDX_W'($urandom_range(0, 63));
  endfunction

  function automatic in_item_t random_instr();
    in_item_t    instr;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      instr.op = OP_W'($urandom_range(OP_IDLE_FIRST, OP_IDLE_LAST));
    end else if (roll < 26) begin
      instr.op = ($urandom_range(0, 1) == 0) ? OP_IMM : OP_SIMM;
    end else begin
      instr.op = OP_W'($urandom_range(OP_ADD, OP_SHR));
    end
    instr.dest_reg = pick_reg();
    instr.src_a    = pick_reg();
    instr.src_b    = pick_reg();
    if (instr.op inside {OP_ADDI, OP_SUBI, OP_SHL, OP_SHR, OP_IMM, OP_SIMM}) begin
      instr.src_b = IDX_W'($urandom_range(0, 63));
    end
    if (instr.op inside {OP_IMM, OP_SIMM}) instr.src_a = IDX_W'($urandom_range(0, 63));
    return instr;
  endfunction

  task automatic issue(input in_item_t instr, input bit known, input out_item_t typed);
    out_item_t   model;
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    if (!in_calm) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = $urandom_range(8, 40);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= instr;
    do @(posedge clk); while (!in_ready);
    model = lane_execute(instr);
    pending_results.push_back(known ? typed : model);
    issued++;
    if (model.write_enable) reg_writes++;
    if (instr.op > OP_SIMM) idle_ops++;
  endtask

  always @(negedge clk) begin : result_ready_gen
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_calm) begin
      out_ready <= 1'b1;
    end else if (roll < 4) begin
      out_ready <= 1'b0;
      out_stall_left <= $urandom_range(8, 40);
    end else begin
      out_ready <= (roll >= 30);
    end
    if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer: we=%0b value=%h flags=%h", $time,
                 out_data.write_enable, out_data.write_value, out_data.flag_vector);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_data.write_enable !== want.write_enable) begin
          $display("%0t: write_enable expected %0b actual %0b", $time,
                   want.write_enable, out_data.write_enable);
          errors++;
        end
        if (out_data.write_value !== want.write_value) begin
          $display("%0t: write_value expected %h actual %h", $time,
                   want.write_value, out_data.write_value);
          errors++;
        end
        if (out_data.flag_vector !== want.flag_vector) begin
          $display("%0t: flag_vector expected %h actual %h", $time,
                   want.flag_vector, out_data.flag_vector);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    lane_row_t rows [$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_flags = '0;

    rows.push_back(row(OP_IDLE_FIRST, 5, 3, 7, 1'b1, 1'b0, 16'h0000, 16'h0000));
    rows.push_back(row(OP_ADD, 1, 0, 0, 1'b1, 1'b1, 16'h0000, FLAGS_ZERO_RESULT));
    rows.push_back(row(OP_IMM, 1, 63, 63, 1'b1, 1'b1, 16'h0FFF, FLAGS_ZERO_RESULT));
    rows.push_back(row(OP_SIMM, 2, 63, 63, 1'b1, 1'b1, 16'hFFFF, FLAGS_ZERO_RESULT));
    rows.push_back(row(OP_SIMM, 3, 32, 0, 1'b1, 1'b1, 16'hF800, FLAGS_ZERO_RESULT));
    rows.push_back(row(OP_IDLE_LAST, 63, 63, 63, 1'b1, 1'b0, 16'h0000, FLAGS_ZERO_RESULT));
    rows.push_back(row(OP_SHL, 4, 1, 3));
    rows.push_back(row(OP_ADDI, 4, 4, 7));
    rows.push_back(row(OP_ADD, 5, 4, 4));
    rows.push_back(row(OP_SUB, 6, 0, 2));
    rows.push_back(row(OP_SUB, 7, 3, 4));
    rows.push_back(row(OP_AND, 8, 2, 3));
    rows.push_back(row(OP_XOR, 9, 2, 2));
    rows.push_back(row(OP_SUBI, 10, 0, 63));
    rows.push_back(row(OP_ADDI, 11, 2, 1));
    rows.push_back(row(OP_SHL, 12, 2, 15));
    rows.push_back(row(OP_SHL, 12, 2, 16));
    rows.push_back(row(OP_SHR, 13, 2, 15));
    rows.push_back(row(OP_SHR, 13, 3, 16));
    rows.push_back(row(OP_SHR, 14, 3, 'o43));
    rows.push_back(row(OP_SHR, 14, 3, 'o77));
    rows.push_back(row(OP_SHR, 15, 4, 'o41));
    // The write to register zero is reported, but later reads still see zero.
    rows.push_back(row(OP_ADD, 0, 2, 2));
    rows.push_back(row(OP_ADD, 16, 0, 2));
    rows.push_back(row(OP_IMM, 63, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) issue(rows[i].instr, rows[i].known, rows[i].result);
    for (int i = 0; i < RANDOM_INSTRS; i++) issue(random_instr(), 1'b0, '0);
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions (%0d directed, %0d no-op codes), %0d register writes.",
             issued, rows.size(), idle_ops, reg_writes);
    $display("Compared %0d result transfers under random gaps and stalls.", checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
